// File: rtl/core/cbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbc_pkg
// Types, constants and state codes shared by the segment clipper modules.
// ----------------------------------------------------------------------------
package cbc_pkg;

	localparam int MAX_PLANES = 8;
	localparam int CNT_W      = $clog2(MAX_PLANES + 1);
	localparam int T_FRAC     = 16;
	localparam int T_W        = T_FRAC + 1;
	localparam int ACC_W      = 36;
	localparam int OFF_W      = 35;
	localparam int DIV_CNT_W  = $clog2(T_FRAC);

	localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC;
	localparam logic [3:0] PLANE_COUNT_RST = 4'd8;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_CLIP = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic [2:0]        plane_index;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic signed [15:0] bx;
		logic signed [15:0] by;
		logic signed [15:0] bz;
	} req_t;

	typedef struct packed {
		logic              visible;
		logic signed [15:0] qx0;
		logic signed [15:0] qy0;
		logic signed [15:0] qz0;
		logic signed [15:0] qx1;
		logic signed [15:0] qy1;
		logic signed [15:0] qz1;
	} res_t;

	typedef struct packed {
		logic signed [15:0]      nx;
		logic signed [15:0]      ny;
		logic signed [15:0]      nz;
		logic signed [OFF_W-1:0] off;
	} plane_t;

	typedef struct packed {
		logic              start;
		logic              ceil_mode;
		logic [ACC_W-1:0]  dividend;
		logic [OFF_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic           done;
		logic [T_W-1:0] quot;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MAC,
		ST_DEC,
		ST_DIV,
		ST_NEXT,
		ST_ROT,
		ST_LERP,
		ST_FIN
	} state_t;

endpackage

// File: rtl/core/cbc_plane_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbc_plane_cell
// One plane slot of the rotating plane ring: written by a load, otherwise
// takes its neighbour's plane on each shift.
// ----------------------------------------------------------------------------
module cbc_plane_cell (
	input  logic            clk,
	input  logic            we,
	input  cbc_pkg::plane_t wr_plane,
	input  logic            shift,
	input  cbc_pkg::plane_t nbr,
	output cbc_pkg::plane_t plane
);

	cbc_pkg::plane_t plane_q;

	always_ff @(posedge clk) begin
		if (we) begin
			plane_q <= wr_plane;
		end else if (shift) begin
			plane_q <= nbr;
		end
	end

	assign plane = plane_q;

endmodule

// File: rtl/core/cbc_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbc_divider
// Restoring fraction divider: dividend * 2^16 / divisor, one bit per cycle,
// with optional round-up. Dividend never exceeds divisor.
// ----------------------------------------------------------------------------
module cbc_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  cbc_pkg::div_req_t req,
	output cbc_pkg::div_rsp_t rsp
);

	logic                          busy_q;
	logic                          done_q;
	logic                          ceil_q;
	logic [cbc_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [cbc_pkg::ACC_W-1:0]     rem_q;
	logic [cbc_pkg::OFF_W-1:0]     div_q;
	logic [cbc_pkg::T_W-1:0]       quot_q;
	logic [cbc_pkg::ACC_W-1:0]     rem2;
	logic                          fit;

	assign rem2 = {rem_q[cbc_pkg::ACC_W-2:0], 1'b0};
	assign fit  = rem2 >= cbc_pkg::ACC_W'(div_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= '0;
				if (req.dividend == cbc_pkg::ACC_W'(req.divisor)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == cbc_pkg::DIV_CNT_W'(cbc_pkg::T_FRAC - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			ceil_q <= req.ceil_mode;
			div_q  <= req.divisor;
			if (req.dividend == cbc_pkg::ACC_W'(req.divisor)) begin
				rem_q  <= '0;
				quot_q <= cbc_pkg::T_ONE;
			end else begin
				rem_q  <= req.dividend;
				quot_q <= '0;
			end
		end else if (busy_q) begin
			rem_q  <= fit ? rem2 - cbc_pkg::ACC_W'(div_q) : rem2;
			quot_q <= {quot_q[cbc_pkg::T_W-2:0], fit};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q + cbc_pkg::T_W'(ceil_q && (rem_q != '0));

endmodule

// File: rtl/core/cyrus_beck_segment_clipper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cyrus_beck_segment_clipper
// Cyrus-Beck clipping of 3D segments against up to eight stored planes.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | cbc_pkg::req_t
//   res     | out       | res_valid/res_stall | cbc_pkg::res_t
//   cfg     | in        | cfg_valid/cfg_ready | plane_count (4 bits)
//
// A load request forms the plane offset. A clip request works through each
// used plane, dividing for each plane that needs it, shifts the ring past
// each slot not visited (none when no plane is used), then forms endpoints
// and hands off; one shared multiplier and a bit-serial divider do the work.
// Reset clears control and sets plane_count to 8; planes are undefined.
// The result waits in an output register; req_stall is high while a
// request is being worked on.
// ----------------------------------------------------------------------------
module cyrus_beck_segment_clipper (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  cbc_pkg::req_t req_item,
	output logic          res_valid,
	input  logic          res_stall,
	output cbc_pkg::res_t res_item,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [3:0]    cfg_data
);

	localparam int NP = cbc_pkg::MAX_PLANES;
	localparam int CW = cbc_pkg::CNT_W;
	localparam int AW = cbc_pkg::ACC_W;
	localparam int TW = cbc_pkg::T_W;

	cbc_pkg::state_t   state_q, state_n;
	cbc_pkg::req_t     item_q;
	cbc_pkg::res_t     res_q;
	cbc_pkg::plane_t   cells [NP];
	cbc_pkg::plane_t   wr_plane;
	cbc_pkg::div_req_t div_req;
	cbc_pkg::div_rsp_t div_rsp;

	logic [3:0]        plane_count_q;
	logic              res_valid_q;
	logic [2:0]        k_q;
	logic [CW-1:0]     i_q, rot_q, n_eff;
	logic              ok_q, enter_q;
	logic [TW-1:0]     te_q, tx_q;
	logic signed [AW-1:0] num_q, den_q, acc_sum, neg_num, neg_den;
	logic signed [15:0] pt_q [6];

	logic signed [16:0] ma;
	logic signed [17:0] mb;
	logic signed [34:0] prod;
	logic signed [34:0] rnd;
	logic signed [16:0] dx, dy, dz;

	logic accept, shift, load_we, wr_out, visible;

	assign accept    = req_valid && !req_stall;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	always_comb begin
		if (int'(plane_count_q) > NP) begin
			n_eff = CW'(NP);
		end else begin
			n_eff = CW'(plane_count_q);
		end
	end

	assign dx = 17'(item_q.bx) - 17'(item_q.ax);
	assign dy = 17'(item_q.by) - 17'(item_q.ay);
	assign dz = 17'(item_q.bz) - 17'(item_q.az);

	// plane ring
	assign wr_plane.nx  = item_q.ax;
	assign wr_plane.ny  = item_q.ay;
	assign wr_plane.nz  = item_q.az;
	assign wr_plane.off = acc_sum[cbc_pkg::OFF_W-1:0];

	for (genvar g = 0; g < NP; g++) begin : g_cell
		cbc_plane_cell u_cell (
			.clk      (clk),
			.we       (load_we && (int'(item_q.plane_index) == g)),
			.wr_plane (wr_plane),
			.shift    (shift),
			.nbr      (cells[(g + 1) % NP]),
			.plane    (cells[g])
		);
	end

	// shared multiplier operands
	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			cbc_pkg::ST_LOAD: begin
				case (k_q)
					3'd0: begin ma = 17'(item_q.ax); mb = 18'(item_q.bx); end
					3'd1: begin ma = 17'(item_q.ay); mb = 18'(item_q.by); end
					default: begin ma = 17'(item_q.az); mb = 18'(item_q.bz); end
				endcase
			end
			cbc_pkg::ST_MAC: begin
				case (k_q)
					3'd0: begin ma = 17'(cells[0].nx); mb = 18'(item_q.ax); end
					3'd1: begin ma = 17'(cells[0].ny); mb = 18'(item_q.ay); end
					3'd2: begin ma = 17'(cells[0].nz); mb = 18'(item_q.az); end
					3'd3: begin ma = 17'(cells[0].nx); mb = 18'(dx); end
					3'd4: begin ma = 17'(cells[0].ny); mb = 18'(dy); end
					default: begin ma = 17'(cells[0].nz); mb = 18'(dz); end
				endcase
			end
			cbc_pkg::ST_LERP: begin
				case (k_q)
					3'd0: begin ma = dx; mb = 18'({1'b0, te_q}); end
					3'd1: begin ma = dy; mb = 18'({1'b0, te_q}); end
					3'd2: begin ma = dz; mb = 18'({1'b0, te_q}); end
					3'd3: begin ma = dx; mb = 18'({1'b0, tx_q}); end
					3'd4: begin ma = dy; mb = 18'({1'b0, tx_q}); end
					default: begin ma = dz; mb = 18'({1'b0, tx_q}); end
				endcase
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign prod = ma * mb;
	assign rnd  = (prod + 35'sd32768) >>> cbc_pkg::T_FRAC;

	always_comb begin
		if (state_q == cbc_pkg::ST_LOAD) begin
			acc_sum = ((k_q == 3'd0) ? AW'(0) : num_q) + AW'(prod);
		end else if (k_q == 3'd0) begin
			acc_sum = AW'(prod) - AW'(cells[0].off);
		end else begin
			acc_sum = num_q + AW'(prod);
		end
	end

	assign neg_num = -num_q;
	assign neg_den = -den_q;
	assign visible = ok_q && (te_q <= tx_q);

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			cbc_pkg::ST_IDLE: begin
				if (req_valid) begin
					if (req_item.cmd == cbc_pkg::CMD_LOAD) begin
						state_n = cbc_pkg::ST_LOAD;
					end else if (n_eff == '0) begin
						state_n = cbc_pkg::ST_LERP;
					end else begin
						state_n = cbc_pkg::ST_MAC;
					end
				end
			end
			cbc_pkg::ST_LOAD: begin
				if (k_q == 3'd2) state_n = cbc_pkg::ST_IDLE;
			end
			cbc_pkg::ST_MAC: begin
				if (k_q == 3'd5) state_n = cbc_pkg::ST_DEC;
			end
			cbc_pkg::ST_DEC: begin
				state_n = div_req.start ? cbc_pkg::ST_DIV : cbc_pkg::ST_NEXT;
			end
			cbc_pkg::ST_DIV: begin
				if (div_rsp.done) state_n = cbc_pkg::ST_NEXT;
			end
			cbc_pkg::ST_NEXT: begin
				if (ok_q && (i_q + 1'b1 < n_eff)) begin
					state_n = cbc_pkg::ST_MAC;
				end else if (int'(rot_q) + 1 < NP) begin
					state_n = cbc_pkg::ST_ROT;
				end else begin
					state_n = cbc_pkg::ST_LERP;
				end
			end
			cbc_pkg::ST_ROT: begin
				if (int'(rot_q) + 1 >= NP) state_n = cbc_pkg::ST_LERP;
			end
			cbc_pkg::ST_LERP: begin
				if (k_q == 3'd5) state_n = cbc_pkg::ST_FIN;
			end
			cbc_pkg::ST_FIN: begin
				if (!res_valid_q || !res_stall) state_n = cbc_pkg::ST_IDLE;
			end
			default: state_n = cbc_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		req_stall         = 1'b1;
		shift             = 1'b0;
		load_we           = 1'b0;
		wr_out            = 1'b0;
		div_req.start     = 1'b0;
		div_req.ceil_mode = 1'b0;
		div_req.dividend  = '0;
		div_req.divisor   = '0;
		case (state_q)
			cbc_pkg::ST_IDLE: req_stall = 1'b0;
			cbc_pkg::ST_LOAD: load_we = (k_q == 3'd2);
			cbc_pkg::ST_DEC: begin
				if (den_q > 0) begin
					div_req.start     = (num_q < 0) && (neg_num <= den_q);
					div_req.ceil_mode = 1'b1;
					div_req.dividend  = neg_num;
					div_req.divisor   = den_q[cbc_pkg::OFF_W-1:0];
				end else if (den_q < 0) begin
					div_req.start     = (num_q >= 0) && (num_q < neg_den);
					div_req.dividend  = num_q;
					div_req.divisor   = neg_den[cbc_pkg::OFF_W-1:0];
				end
			end
			cbc_pkg::ST_NEXT, cbc_pkg::ST_ROT: shift = 1'b1;
			cbc_pkg::ST_FIN: wr_out = !res_valid_q || !res_stall;
			default: req_stall = 1'b1;
		endcase
	end

	cbc_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= cbc_pkg::ST_IDLE;
			plane_count_q <= cbc_pkg::PLANE_COUNT_RST;
			res_valid_q   <= 1'b0;
			k_q           <= '0;
			i_q           <= '0;
			rot_q         <= '0;
		end else begin
			state_q <= state_n;
			k_q     <= (state_n != state_q) ? 3'd0 : k_q + 1'b1;
			if (cfg_valid && cfg_ready) plane_count_q <= cfg_data;
			if (wr_out) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (accept) begin
				i_q   <= '0;
				rot_q <= '0;
			end else if (shift) begin
				i_q   <= i_q + 1'b1;
				rot_q <= rot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req_item;
			te_q   <= '0;
			tx_q   <= cbc_pkg::T_ONE;
			ok_q   <= 1'b1;
		end
		if (state_q == cbc_pkg::ST_LOAD) begin
			num_q <= acc_sum;
		end
		if (state_q == cbc_pkg::ST_MAC) begin
			if (k_q < 3'd3) begin
				num_q <= acc_sum;
			end else begin
				den_q <= ((k_q == 3'd3) ? AW'(0) : den_q) + AW'(prod);
			end
		end
		if (state_q == cbc_pkg::ST_DEC) begin
			enter_q <= den_q > 0;
			if (den_q == 0) begin
				if (num_q < 0) ok_q <= 1'b0;
			end else if (den_q > 0) begin
				if ((num_q < 0) && (neg_num > den_q)) ok_q <= 1'b0;
			end else if (num_q < 0) begin
				ok_q <= 1'b0;
			end
		end
		if ((state_q == cbc_pkg::ST_DIV) && div_rsp.done) begin
			if (enter_q) begin
				if (div_rsp.quot > te_q) te_q <= div_rsp.quot;
			end else if (div_rsp.quot < tx_q) begin
				tx_q <= div_rsp.quot;
			end
		end
		if (state_q == cbc_pkg::ST_LERP) begin
			case (k_q)
				3'd0: pt_q[0] <= item_q.ax + rnd[15:0];
				3'd1: pt_q[1] <= item_q.ay + rnd[15:0];
				3'd2: pt_q[2] <= item_q.az + rnd[15:0];
				3'd3: pt_q[3] <= item_q.ax + rnd[15:0];
				3'd4: pt_q[4] <= item_q.ay + rnd[15:0];
				default: pt_q[5] <= item_q.az + rnd[15:0];
			endcase
		end
		if (wr_out) begin
			res_q.visible <= visible;
			res_q.qx0     <= visible ? pt_q[0] : 16'sd0;
			res_q.qy0     <= visible ? pt_q[1] : 16'sd0;
			res_q.qz0     <= visible ? pt_q[2] : 16'sd0;
			res_q.qx1     <= visible ? pt_q[3] : 16'sd0;
			res_q.qy1     <= visible ? pt_q[4] : 16'sd0;
			res_q.qz1     <= visible ? pt_q[5] : 16'sd0;
		end
	end

endmodule

// File: verif/cyrus_beck_segment_clipper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cyrus_beck_segment_clipper_tb
// Drives plane loads and segment clips with random gaps and output stalls.
// Each result is checked field by field against an in-bench clipper, under
// several plane counts: zero, one, three, six, the largest, above the largest and random.
// ----------------------------------------------------------------------------
module cyrus_beck_segment_clipper_tb;

	class clip_scoreboard;
		longint nrm[cbc_pkg::MAX_PLANES][3];
		longint off[cbc_pkg::MAX_PLANES];
		int unsigned count = 8;
		cbc_pkg::res_t pending[$];
		int errors = 0;

		function automatic longint rdiv(longint v);
			return v >>> 16;
		endfunction

		function automatic void note_request(cbc_pkg::req_t r);
			longint a[3], d[3], num, den, m, t, te, tx;
			int unsigned n;
			bit ok;
			cbc_pkg::res_t e;
			a[0] = longint'(r.ax); a[1] = longint'(r.ay); a[2] = longint'(r.az);
			d[0] = longint'(r.bx) - a[0];
			d[1] = longint'(r.by) - a[1];
			d[2] = longint'(r.bz) - a[2];
			if (r.cmd == cbc_pkg::CMD_LOAD) begin
				nrm[r.plane_index][0] = a[0];
				nrm[r.plane_index][1] = a[1];
				nrm[r.plane_index][2] = a[2];
				off[r.plane_index] = a[0] * r.bx + a[1] * r.by + a[2] * r.bz;
				return;
			end
			te = 0;
			tx = 65536;
			ok = 1;
			n = (count > cbc_pkg::MAX_PLANES) ? cbc_pkg::MAX_PLANES : count;
			for (int i = 0; i < n && ok; i++) begin
				num = nrm[i][0] * a[0] + nrm[i][1] * a[1] + nrm[i][2] * a[2] - off[i];
				den = nrm[i][0] * d[0] + nrm[i][1] * d[1] + nrm[i][2] * d[2];
				if (den == 0) begin
					if (num < 0) ok = 0;
				end else if (den > 0) begin
					if (num < 0) begin
						m = -num;
						if (m > den) ok = 0;
						else begin
							t = (m * 65536 + den - 1) / den;
							if (t > te) te = t;
						end
					end
				end else begin
					if (num < 0) ok = 0;
					else if (num < -den) begin
						t = (num * 65536) / (-den);
						if (t < tx) tx = t;
					end
				end
			end
			if (ok && te > tx) ok = 0;
			e = '0;
			e.visible = ok;
			if (ok) begin
				e.qx0 = 16'(a[0] + rdiv(d[0] * te + 32768));
				e.qy0 = 16'(a[1] + rdiv(d[1] * te + 32768));
				e.qz0 = 16'(a[2] + rdiv(d[2] * te + 32768));
				e.qx1 = 16'(a[0] + rdiv(d[0] * tx + 32768));
				e.qy1 = 16'(a[1] + rdiv(d[1] * tx + 32768));
				e.qz1 = 16'(a[2] + rdiv(d[2] * tx + 32768));
			end
			pending.push_back(e);
		endfunction

		function automatic void cmp(string name, logic [15:0] e, logic [15:0] g);
			if (g !== e) begin
				$error("%s expected %0d got %0d", name, $signed(e), $signed(g));
				errors++;
			end
		endfunction

		function automatic void check_result(cbc_pkg::res_t g);
			cbc_pkg::res_t e;
			if (pending.size() == 0) begin
				$error("unexpected result");
				errors++;
				return;
			end
			e = pending.pop_front();
			cmp("visible", 16'(e.visible), 16'(g.visible));
			cmp("qx0", e.qx0, g.qx0);
			cmp("qy0", e.qy0, g.qy0);
			cmp("qz0", e.qz0, g.qz0);
			cmp("qx1", e.qx1, g.qx1);
			cmp("qy1", e.qy1, g.qy1);
			cmp("qz1", e.qz1, g.qz1);
		endfunction
	endclass

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE = 400;

	logic clk = 0;
	logic arst_n = 0;
	logic req_valid = 0;
	logic req_stall;
	cbc_pkg::req_t req_item = '0;
	logic res_valid;
	logic res_stall = 0;
	cbc_pkg::res_t res_item;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [3:0] cfg_data = '0;

	clip_scoreboard sb = new();
	bit calm = 0;
	int stall_left = 0;
	int quiet_cycles = 0;

	cyrus_beck_segment_clipper uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
		.res_valid(res_valid), .res_stall(res_stall), .res_item(res_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	always @(posedge clk) begin
		if (res_valid && !res_stall) begin
			int w;
			sb.check_result(res_item);
			w = calm ? 0 : $urandom_range(0, 5);
			stall_left <= w;
			res_stall <= (w != 0);
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			if (stall_left == 1) res_stall <= 0;
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else if (arst_n) begin
			if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send(cbc_pkg::req_t r);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			req_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1;
		req_item <= r;
		do @(posedge clk); while (!(req_valid && !req_stall));
		sb.note_request(r);
	endtask

	task automatic settle();
		req_valid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_count(logic [3:0] v);
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		sb.count = 32'(v);
		cfg_valid <= 0;
	endtask

	task automatic load(int slot, int nx, int ny, int nz, int px, int py, int pz);
		cbc_pkg::req_t r;
		r.cmd = cbc_pkg::CMD_LOAD;
		r.plane_index = 3'(slot);
		r.ax = 16'(nx); r.ay = 16'(ny); r.az = 16'(nz);
		r.bx = 16'(px); r.by = 16'(py); r.bz = 16'(pz);
		send(r);
	endtask

	task automatic clip(int x0, int y0, int z0, int x1, int y1, int z1);
		cbc_pkg::req_t r;
		r.cmd = cbc_pkg::CMD_CLIP;
		r.plane_index = 3'($urandom);
		r.ax = 16'(x0); r.ay = 16'(y0); r.az = 16'(z0);
		r.bx = 16'(x1); r.by = 16'(y1); r.bz = 16'(z1);
		send(r);
	endtask

	task automatic load_box(int h);
		load(0, 4096, 0, 0, -h, 0, 0);
		load(1, -4096, 0, 0, h, 0, 0);
		load(2, 0, 4096, 0, 0, -h, 0);
		load(3, 0, -4096, 0, 0, h, 0);
		load(4, 0, 0, 4096, 0, 0, -h);
		load(5, 0, 0, -4096, 0, 0, h);
		load(6, 0, 0, 0, 1234, -77, 5);
		load(7, -2896, -2896, -2896, h, h, h);
	endtask

	function automatic int coord();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1) ? 32767 : -32768;
			1: return $signed(16'($urandom));
			default: return $urandom_range(0, 24576) - 12288;
		endcase
	endfunction

	task automatic random_item();
		int s;
		if ($urandom_range(0, 99) < 12) begin
			s = $urandom_range(0, 7);
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 2))
					0: load(s, $urandom_range(0, 1) ? 4096 : -4096,
						$urandom_range(0, 512) - 256, $urandom_range(0, 512) - 256,
						coord(), coord(), coord());
					1: load(s, $urandom_range(0, 512) - 256,
						$urandom_range(0, 1) ? 4096 : -4096,
						$urandom_range(0, 512) - 256, coord(), coord(), coord());
					default: load(s, $urandom_range(0, 512) - 256,
						$urandom_range(0, 512) - 256,
						$urandom_range(0, 1) ? 4096 : -4096, coord(), coord(), coord());
				endcase
			end else
				load(s, coord(), coord(), coord(), coord(), coord(), coord());
		end else
			clip(coord(), coord(), coord(), coord(), coord(), coord());
	endtask

	initial begin
		logic [3:0] counts[6];
		counts = '{4'd8, 4'd0, 4'd1, 4'd15, 4'd6, 4'd3};
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		calm = 1;
		load_box(8192);
		clip(0, 0, 0, 4096, 4096, 4096);
		clip(-20000, 0, 0, 20000, 0, 0);
		clip(-20000, 10000, 0, 20000, 10000, 0);
		clip(-30000, 0, 0, -20000, 0, 0);
		clip(20000, 0, 0, 30000, 0, 0);
		clip(-32768, -32768, -32768, 32767, 32767, 32767);
		clip(32767, 32767, 32767, -32768, -32768, -32768);
		clip(-32768, 32767, 0, 32767, -32768, 0);
		clip(100, 200, 300, 100, 200, 300);
		clip(20000, 20000, 0, 20000, 20000, 0);
		clip(-10000, 9000, 0, 9000, -10000, 0);
		load(6, 0, 0, 0, 0, 0, 0);
		clip(8192, -8192, 8192, -8192, 8192, -8192);
		settle();

		for (int p = 0; p < 7; p++) begin
			calm = (p == 2);
			write_count(p < 6 ? counts[p] : 4'($urandom));
			load_box($urandom_range(2048, 16384));
			repeat (145) random_item();
			settle();
		end

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
